// ===== rtl/teq_pkg.sv =====
package teq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ID_WIDTH    = 16;

    localparam int TIME_W   = 32;
    localparam int CMD_W    = 3;
    localparam int EXT_ID_W = 16;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W    = $clog2(TABLE_DEPTH);

    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_UNCHK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP_AT   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LISTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PAST = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef logic [ID_WIDTH-1:0] t_id;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        t_id               id;
    } t_entry;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   shift;
        t_entry ins_ent;
    } t_cell_ctl;

    // Control from the sequencer to the chain.
    typedef struct packed {
        t_cell_ctl        slot;
        logic             load_en;
        logic [IDX_W-1:0] ptr;
        logic [CNT_W-1:0] count;
    } t_chain_ctl;

    function automatic t_id id_from_port(input logic [EXT_ID_W-1:0] v);
        t_id r;
        for (int i = 0; i < ID_WIDTH; i++) begin
            r[i] = (i < EXT_ID_W) ? v[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [EXT_ID_W-1:0] id_to_port(input t_id v);
        logic [EXT_ID_W-1:0] r;
        for (int i = 0; i < EXT_ID_W; i++) begin
            r[i] = (i < ID_WIDTH) ? v[i] : 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/teq_req_if.sv =====
interface teq_req_if;
    logic                          valid;
    logic                          ready;
    logic [teq_pkg::CMD_W-1:0]     cmd;
    logic [teq_pkg::TIME_W-1:0]    time_value;
    logic [teq_pkg::EXT_ID_W-1:0]  event_id;

    modport source (output valid, cmd, time_value, event_id, input ready);
    modport sink   (input valid, cmd, time_value, event_id, output ready);
endinterface

// ===== rtl/teq_res_if.sv =====
interface teq_res_if;
    logic                          valid;
    logic                          ready;
    logic [teq_pkg::KIND_W-1:0]    kind;
    logic [teq_pkg::TIME_W-1:0]    event_time;
    logic [teq_pkg::EXT_ID_W-1:0]  event_id_res;
    logic [teq_pkg::STAT_W-1:0]    status;
    logic                          last;

    modport source (output valid, kind, event_time, event_id_res, status, last, input ready);
    modport sink   (input valid, kind, event_time, event_id_res, status, last, output ready);
endinterface

// ===== rtl/teq_cell.sv =====
// One table slot. On an insert the slot keeps its entry, takes the new entry or
// takes its left neighbour's; on a scan step it takes its right neighbour's or
// the head entry that is being written back behind the unscanned ones.
module teq_cell (
    input  logic               i_clk,
    input  teq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic               i_load,
    input  teq_pkg::t_entry    i_head,
    input  teq_pkg::t_entry    i_left,
    input  teq_pkg::t_entry    i_right,
    input  logic               i_left_le,
    output teq_pkg::t_entry    o_ent,
    output logic               o_le
);
    teq_pkg::t_entry r_ent;
    teq_pkg::t_entry n_ent;

    assign o_le  = i_valid && (r_ent.due <= i_ctl.ins_ent.due);
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.ins) begin
            if (!o_le) begin
                n_ent = i_left_le ? i_ctl.ins_ent : i_left;
            end
        end else if (i_ctl.shift) begin
            n_ent = i_load ? i_head : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end
endmodule

// ===== rtl/teq_chain.sv =====
// Row of table cells with neighbour links; cell 0 holds the head.
module teq_chain (
    input  logic                i_clk,
    input  teq_pkg::t_chain_ctl i_ctl,
    output teq_pkg::t_entry     o_head
);
    teq_pkg::t_entry ent [teq_pkg::TABLE_DEPTH];
    logic            le  [teq_pkg::TABLE_DEPTH];

    assign o_head = ent[0];

    for (genvar k = 0; k < teq_pkg::TABLE_DEPTH; k++) begin : g_cell
        logic            valid;
        logic            load;
        logic            left_le;
        teq_pkg::t_entry left;
        teq_pkg::t_entry right;

        assign valid = (teq_pkg::CNT_W'(k) < i_ctl.count);
        assign load  = i_ctl.load_en && (i_ctl.ptr == teq_pkg::IDX_W'(k));

        if (k == 0) begin : g_first
            assign left_le = 1'b1;
            assign left    = ent[k];
        end else begin : g_inner
            assign left_le = le[k-1];
            assign left    = ent[k-1];
        end

        if (k == teq_pkg::TABLE_DEPTH - 1) begin : g_last
            assign right = ent[k];
        end else begin : g_body
            assign right = ent[k+1];
        end

        teq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl.slot),
            .i_valid   (valid),
            .i_load    (load),
            .i_head    (ent[0]),
            .i_left    (left),
            .i_right   (right),
            .i_left_le (left_le),
            .o_ent     (ent[k]),
            .o_le      (le[k])
        );
    end
endmodule

// ===== rtl/timed_event_queue.sv =====
// A request is accepted only in the idle state. An add updates the table as it is
// accepted, then the closing state registers its closing result. Remove, advance and
// dump scan the cell chain one entry per cycle, but a step that reports an entry
// waits while the output is stalled; the closing result is sent after the last step.
// Reset (synchronous, active low) empties the table and clears the current time.
//
// The table lives in a chain of cells kept sorted by due time, ties in insertion
// order. On an insert all cells update together: every cell compares its own time with
// the new one and, from its left neighbour's answer, knows whether to keep its
// entry, take the new one or take its left neighbour's entry.
//
// The commands that walk the table rotate it: in each step every cell takes its
// right neighbour's entry, and the head (cell 0) is examined and written back
// behind the entries not yet scanned. After entry_count steps the table is back in
// its original order. A remove simply does not write back matching entries, which
// compacts the table as it goes.
module timed_event_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    teq_req_if.sink         i_req,
    teq_res_if.source       o_res
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    localparam logic [teq_pkg::TIME_W-1:0] TIME_MAX = '1;

    logic [1:0]                   r_state, n_state;
    logic [teq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [teq_pkg::TIME_W-1:0]   r_cur, n_cur;
    logic [teq_pkg::CNT_W-1:0]    r_step, n_step;
    logic [teq_pkg::CNT_W-1:0]    r_wr, n_wr;
    logic [teq_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [teq_pkg::TIME_W-1:0]   r_tv, n_tv;
    logic [teq_pkg::TIME_W-1:0]   r_lo, n_lo;
    logic [teq_pkg::STAT_W-1:0]   r_stat, n_stat;

    logic                         r_out_valid, n_out_valid;
    logic [teq_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [teq_pkg::TIME_W-1:0]   r_otime, n_otime;
    logic [teq_pkg::EXT_ID_W-1:0] r_oid, n_oid;
    logic [teq_pkg::STAT_W-1:0]   r_ostat, n_ostat;
    logic                         r_olast, n_olast;

    teq_pkg::t_chain_ctl          chain_ctl;
    teq_pkg::t_entry              head;

    logic                         accept;
    logic                         out_free;
    logic [teq_pkg::TIME_W:0]     adv_sum;
    logic                         is_scan_cmd;
    logic                         keep;
    logic                         emit;
    logic                         step_ok;
    logic [teq_pkg::CNT_W-1:0]    ptr_full;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign adv_sum  = {1'b0, r_cur} + {1'b0, i_req.time_value};

    assign i_req.ready = (r_state == ST_IDLE);

    assign is_scan_cmd = (i_req.cmd == teq_pkg::CMD_REMOVE) ||
                         (i_req.cmd == teq_pkg::CMD_ADVANCE) ||
                         (i_req.cmd == teq_pkg::CMD_DUMP) ||
                         (i_req.cmd == teq_pkg::CMD_DUMP_AT);

    // A removed entry is not written back; everything else is.
    assign keep = (r_cmd != teq_pkg::CMD_REMOVE) || (head.due != r_tv);

    // Only entries due after the time at the start of the command are reported;
    // for an advance, r_cur already holds the new time.
    always_comb begin
        unique case (r_cmd)
            teq_pkg::CMD_ADVANCE: emit = (head.due > r_lo) && (head.due <= r_cur);
            teq_pkg::CMD_DUMP:    emit = (head.due > r_lo);
            teq_pkg::CMD_DUMP_AT: emit = (head.due > r_lo) && (head.due == r_tv);
            default:              emit = 1'b0;
        endcase
    end

    assign step_ok = (r_state == ST_SCAN) && (!emit || out_free);

    // The written-back head goes just behind the unscanned entries and the ones
    // already kept.
    assign ptr_full = r_count - teq_pkg::CNT_W'(1) - r_step + r_wr;

    always_comb begin
        chain_ctl                  = '0;
        chain_ctl.count            = r_count;
        chain_ctl.ptr              = ptr_full[teq_pkg::IDX_W-1:0];
        chain_ctl.load_en          = keep;
        chain_ctl.slot.shift       = step_ok;
        chain_ctl.slot.ins_ent.due = i_req.time_value;
        chain_ctl.slot.ins_ent.id  = teq_pkg::id_from_port(i_req.event_id);

        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_step      = r_step;
        n_wr        = r_wr;
        n_cmd       = r_cmd;
        n_tv        = r_tv;
        n_lo        = r_lo;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_otime     = r_otime;
        n_oid       = r_oid;
        n_ostat     = r_ostat;
        n_olast     = r_olast;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = i_req.cmd;
                    n_tv   = i_req.time_value;
                    n_lo   = r_cur;
                    n_stat = teq_pkg::STAT_OK;
                    n_step = '0;
                    n_wr   = '0;
                    n_state = ST_CLOSE;
                    if (i_req.cmd == teq_pkg::CMD_ADD ||
                        i_req.cmd == teq_pkg::CMD_ADD_UNCHK) begin
                        // The past check of a checked add comes before the full check.
                        if (i_req.cmd == teq_pkg::CMD_ADD && i_req.time_value <= r_cur) begin
                            n_stat = teq_pkg::STAT_PAST;
                        end else if (r_count == teq_pkg::CNT_W'(teq_pkg::TABLE_DEPTH)) begin
                            n_stat = teq_pkg::STAT_FULL;
                        end else begin
                            chain_ctl.slot.ins = 1'b1;
                            n_count = r_count + teq_pkg::CNT_W'(1);
                        end
                    end else if (is_scan_cmd) begin
                        if (i_req.cmd == teq_pkg::CMD_ADVANCE) begin
                            n_cur = adv_sum[teq_pkg::TIME_W] ? TIME_MAX
                                                             : adv_sum[teq_pkg::TIME_W-1:0];
                        end
                        if (r_count != '0) begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_kind  = (r_cmd == teq_pkg::CMD_ADVANCE) ? teq_pkg::KIND_FIRED
                                                                  : teq_pkg::KIND_LISTED;
                        n_otime = head.due;
                        n_oid   = teq_pkg::id_to_port(head.id);
                        n_ostat = teq_pkg::STAT_OK;
                        n_olast = 1'b0;
                    end
                    n_step = r_step + teq_pkg::CNT_W'(1);
                    n_wr   = r_wr + (keep ? teq_pkg::CNT_W'(1) : '0);
                    if (r_step == r_count - teq_pkg::CNT_W'(1)) begin
                        n_count = n_wr;
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind  = teq_pkg::KIND_CLOSE;
                    n_otime = '0;
                    n_oid   = '0;
                    n_ostat = r_stat;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    teq_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (chain_ctl),
        .o_head (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_step      <= '0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_step      <= n_step;
            r_wr        <= n_wr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_tv    <= n_tv;
        r_lo    <= n_lo;
        r_stat  <= n_stat;
        r_kind  <= n_kind;
        r_otime <= n_otime;
        r_oid   <= n_oid;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.event_time   = r_otime;
    assign o_res.event_id_res = r_oid;
    assign o_res.status       = r_ostat;
    assign o_res.last         = r_olast;
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import teq_pkg::*;

    // Clock of 12 ns, reset held low at the start and never again.
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 4;

    // A scan of a full table plus the closing request, with some margin. This is
    // how long the bench waits after the last expected result before it ends.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

    // Several times what the slowest correct run needs, even with every request
    // scanning a full table under the longest receiver stalls.
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int RANDOM_REQUESTS = 460;

    // The two command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef logic [EXT_ID_W-1:0] t_port_id;

    // One result as it should leave the block.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] due;
        t_port_id          ident;
        logic [STAT_W-1:0] status;
        logic              closing;
    } t_outcome;

    // One row of the directed script. Where typed is set, the closing status is
    // read straight off the row and the request can produce nothing else.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] tv;
        t_port_id          pid;
        bit                typed;
        logic [STAT_W-1:0] typed_stat;
    } t_stim;

    localparam int HEAD_ROWS   = 21;
    localparam int SCRIPT_ROWS = 26;

    // The head runs straight after reset; the tail runs last of all, because it
    // drives the current time to its ceiling, after which no checked add can ever
    // succeed again.
    t_stim script_rows [SCRIPT_ROWS] = '{
        '{CMD_DUMP,      32'd0,          16'h0000, 1'b1, STAT_OK},   // empty table
        '{CMD_ADVANCE,   32'd0,          16'h0000, 1'b1, STAT_OK},   // zero advance
        '{CMD_ADD,       32'd0,          16'hFFFF, 1'b1, STAT_PAST}, // due now, refused
        '{CMD_ADD,       32'hFFFF_FFFF,  16'hFFFF, 1'b1, STAT_OK},   // latest possible time
        '{CMD_ADD,       32'd1,          16'h0000, 1'b1, STAT_OK},
        '{CMD_ADD_UNCHK, 32'd0,          16'h1234, 1'b1, STAT_OK},   // stored in the past
        '{CMD_ADD,       32'd100,        16'hA5A5, 1'b1, STAT_OK},
        '{CMD_ADD,       32'd100,        16'h5A5A, 1'b1, STAT_OK},   // tie, goes behind
        '{CMD_ADD,       32'd50,         16'h0007, 1'b1, STAT_OK},
        '{CMD_DUMP,      32'd0,          16'h0000, 1'b0, STAT_OK},
        '{CMD_DUMP_AT,   32'd100,        16'h0000, 1'b0, STAT_OK},
        '{CMD_ADVANCE,   32'd60,         16'h0000, 1'b0, STAT_OK},
        '{CMD_ADD,       32'd60,         16'h0003, 1'b1, STAT_PAST}, // equal to now
        '{CMD_ADD,       32'd59,         16'h0004, 1'b1, STAT_PAST},
        '{CMD_DUMP_AT,   32'd50,         16'h0000, 1'b0, STAT_OK},   // fired, not pending
        '{CMD_REMOVE,    32'd50,         16'h0000, 1'b1, STAT_OK},
        '{CMD_REMOVE,    32'd0,          16'h0000, 1'b1, STAT_OK},
        '{CMD_SPARE_LO,  32'd0,          16'h0000, 1'b1, STAT_OK},
        '{CMD_SPARE_HI,  32'hFFFF_FFFF,  16'hFFFF, 1'b1, STAT_OK},
        '{CMD_ADVANCE,   32'd40,         16'h0000, 1'b0, STAT_OK},
        '{CMD_REMOVE,    32'd100,        16'h0000, 1'b1, STAT_OK},
        // Tail.
        '{CMD_ADVANCE,   32'hFFFF_FFFF,  16'h0000, 1'b0, STAT_OK},   // saturates
        '{CMD_ADD,       32'hFFFF_FFFF,  16'h8001, 1'b1, STAT_PAST},
        '{CMD_ADD_UNCHK, 32'd7,          16'h00FF, 1'b0, STAT_OK},
        '{CMD_DUMP,      32'd0,          16'h0000, 1'b0, STAT_OK},
        '{CMD_REMOVE,    32'hFFFF_FFFF,  16'h0000, 1'b1, STAT_OK}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    teq_req_if req_bus ();
    teq_res_if res_bus ();

    timed_event_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the event table, kept sorted exactly as the block keeps it.
    logic [TIME_W-1:0] shadow_due [TABLE_DEPTH];
    t_id               shadow_id  [TABLE_DEPTH];
    int                shadow_count = 0;
    logic [TIME_W-1:0] shadow_now   = '0;

    // Results of the request just accepted, and every result still owed by the
    // block, oldest first.
    t_outcome fresh_outcomes   [$];
    t_outcome awaited_results  [$];

    int  mismatches    = 0;
    int  requests_sent = 0;
    int  cycle_count   = 0;
    int  burst_left    = 1;
    bit  holding_valid = 1'b0;

    // Receiver pattern state.
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_period = 2;
    int rx_tick   = 0;

    t_outcome oldest;

    function automatic void note_event(input logic [KIND_W-1:0] kind, input int idx);
        t_outcome o;
        o.kind    = kind;
        o.due     = shadow_due[idx];
        o.ident   = t_port_id'(shadow_id[idx]);
        o.status  = STAT_OK;
        o.closing = 1'b0;
        fresh_outcomes.insert(fresh_outcomes.size(), o);
    endfunction

    // Insert behind every entry due at or before t, so that ties keep their order.
    function automatic logic [STAT_W-1:0] insert_entry(input logic [TIME_W-1:0] t,
                                                       input t_port_id pid);
        int pos;
        int k;
        if (shadow_count >= TABLE_DEPTH) begin
            return STAT_FULL;
        end
        pos = 0;
        while (pos < shadow_count && shadow_due[pos] <= t) begin
            pos++;
        end
        for (k = shadow_count; k > pos; k--) begin
            shadow_due[k] = shadow_due[k-1];
            shadow_id[k]  = shadow_id[k-1];
        end
        shadow_due[pos] = t;
        shadow_id[pos]  = t_id'(pid);
        shadow_count++;
        return STAT_OK;
    endfunction

    // Works out what the block must answer to one command, and updates the
    // shadow table as the block updates its own.
    function automatic void predict_command(input logic [CMD_W-1:0] c,
                                            input logic [TIME_W-1:0] tv,
                                            input t_port_id pid);
        logic [STAT_W-1:0] stat;
        logic [TIME_W-1:0] old_now;
        logic [TIME_W:0]   sum;
        int                wr;
        int                k;
        t_outcome          close;
        fresh_outcomes.delete();
        stat = STAT_OK;
        case (c)
            CMD_ADD: begin
                // The past check wins over the full check.
                if (tv <= shadow_now) begin
                    stat = STAT_PAST;
                end else begin
                    stat = insert_entry(tv, pid);
                end
            end
            CMD_ADD_UNCHK: begin
                stat = insert_entry(tv, pid);
            end
            CMD_REMOVE: begin
                wr = 0;
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_due[k] != tv) begin
                        shadow_due[wr] = shadow_due[k];
                        shadow_id[wr]  = shadow_id[k];
                        wr++;
                    end
                end
                shadow_count = wr;
            end
            CMD_ADVANCE: begin
                old_now    = shadow_now;
                sum        = {1'b0, shadow_now} + {1'b0, tv};
                shadow_now = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_due[k] > old_now && shadow_due[k] <= shadow_now) begin
                        note_event(KIND_FIRED, k);
                    end
                end
            end
            CMD_DUMP: begin
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_due[k] > shadow_now) begin
                        note_event(KIND_LISTED, k);
                    end
                end
            end
            CMD_DUMP_AT: begin
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_due[k] > shadow_now && shadow_due[k] == tv) begin
                        note_event(KIND_LISTED, k);
                    end
                end
            end
            default: begin
            end
        endcase
        close.kind    = KIND_CLOSE;
        close.due     = '0;
        close.ident   = '0;
        close.status  = stat;
        close.closing = 1'b1;
        fresh_outcomes.insert(fresh_outcomes.size(), close);
    endfunction

    // Sends one request and books its expected results once it is accepted. The
    // sender works in bursts: within a burst valid stays high from one request
    // to the next, and between bursts it drops for a random gap.
    task automatic push_request(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] tv,
                                input t_port_id pid, input bit typed = 1'b0,
                                input logic [STAT_W-1:0] typed_stat = STAT_OK);
        t_outcome close;
        req_bus.valid      <= 1'b1;
        req_bus.cmd        <= c;
        req_bus.time_value <= tv;
        req_bus.event_id   <= pid;
        holding_valid       = 1'b1;
        @(posedge i_clk);
        while (!req_bus.ready) begin
            @(posedge i_clk);
        end
        predict_command(c, tv, pid);
        if (typed) begin
            close.kind    = KIND_CLOSE;
            close.due     = '0;
            close.ident   = '0;
            close.status  = typed_stat;
            close.closing = 1'b1;
            awaited_results.insert(awaited_results.size(), close);
        end else begin
            foreach (fresh_outcomes[k]) begin
                awaited_results.insert(awaited_results.size(), fresh_outcomes[k]);
            end
        end
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            req_bus.valid <= 1'b0;
            holding_valid  = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            // Now and then a long burst, so that some stretches run without gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Holds the sender off until the block has delivered everything it owes.
    task automatic drain_results();
        if (holding_valid) begin
            req_bus.valid <= 1'b0;
            holding_valid  = 1'b0;
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic play_rows(input int first, input int stop);
        for (int r = first; r < stop; r++) begin
            push_request(script_rows[r].cmd, script_rows[r].tv, script_rows[r].pid,
                         script_rows[r].typed, script_rows[r].typed_stat);
        end
    endtask

    // Fills the table to the brim, knocks on it while full, lists what is pending, fires
    // what falls due, then removes every entry by its time until the table is empty again.
    task automatic fill_and_empty();
        logic [TIME_W-1:0] t;
        drain_results();
        while (shadow_count < TABLE_DEPTH) begin
            if (shadow_count > 0 && $urandom_range(0, 3) == 0) begin
                t = shadow_due[$urandom_range(0, shadow_count - 1)];
            end else begin
                t = shadow_now + $urandom_range(1, 400);
            end
            push_request(($urandom_range(0, 3) == 0) ? CMD_ADD_UNCHK : CMD_ADD, t,
                         t_port_id'($urandom_range(0, 65535)));
        end
        push_request(CMD_ADD, shadow_now + 5, t_port_id'($urandom_range(0, 65535)));
        push_request(CMD_ADD_UNCHK, shadow_now, t_port_id'($urandom_range(0, 65535)));
        push_request(CMD_ADD, shadow_now, t_port_id'($urandom_range(0, 65535)));
        push_request(CMD_DUMP, '0, '0);
        push_request(CMD_DUMP_AT, shadow_due[$urandom_range(0, TABLE_DEPTH - 1)], '0);
        push_request(CMD_ADVANCE, $urandom_range(200, 400), '0);
        while (shadow_count > 0) begin
            push_request(CMD_REMOVE, shadow_due[$urandom_range(0, shadow_count - 1)], '0);
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: ready follows one of several patterns, each held for a random
    // stretch - always ready, random stalls, a short period with one stall, and
    // long stalls broken by a single ready cycle.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            rx_left   <= $urandom_range(16, 160);
            rx_period <= $urandom_range(2, 8);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0:       res_bus.ready <= 1'b1;
            1:       res_bus.ready <= ($urandom_range(0, 2) != 0);
            2:       res_bus.ready <= ((rx_tick % rx_period) != 0);
            default: res_bus.ready <= ((rx_tick % 8) == 0);
        endcase
    end

    // Every result taken by the receiver is matched against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: kind %0d time 0x%0h id 0x%0h",
                       res_bus.kind, res_bus.event_time, res_bus.event_id_res);
                mismatches++;
            end else begin
                oldest = awaited_results.pop_front();
                compare_field("kind",         oldest.kind,    res_bus.kind);
                compare_field("event_time",   oldest.due,     res_bus.event_time);
                compare_field("event_id_res", oldest.ident,   res_bus.event_id_res);
                compare_field("status",       oldest.status,  res_bus.status);
                compare_field("last",         oldest.closing, res_bus.last);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int                pick;
        int                n;
        logic [CMD_W-1:0]  c;
        logic [TIME_W-1:0] t;

        req_bus.valid      = 1'b0;
        req_bus.cmd        = CMD_ADD;
        req_bus.time_value = '0;
        req_bus.event_id   = '0;
        res_bus.ready      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening, then one full fill and empty with the sender held
        // off until the block has gone quiet.
        play_rows(0, HEAD_ROWS);
        fill_and_empty();

        // Random traffic, mostly built from sensible sequences: schedule a few
        // events, move time on and clear what fired, query the table, plus some
        // noise and an occasional fill to the limit.
        while (requests_sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0: t = (shadow_count > 0) ?
                               shadow_due[$urandom_range(0, shadow_count - 1)] : shadow_now;
                        1: t = shadow_now - $urandom_range(0, 3);
                        2: t = $urandom;
                        default: t = shadow_now + $urandom_range(1, 200);
                    endcase
                    c = ($urandom_range(0, 4) == 0) ? CMD_ADD_UNCHK : CMD_ADD;
                    push_request(c, t, t_port_id'($urandom_range(0, 65535)));
                end
            end else if (pick < 60) begin
                push_request(CMD_ADVANCE,
                             ($urandom_range(0, 5) == 0) ? '0 : $urandom_range(1, 150), '0);
                if (shadow_count > 0 && $urandom_range(0, 4) < 3) begin
                    push_request(CMD_REMOVE,
                                 shadow_due[$urandom_range(0, shadow_count - 1)], '0);
                end
            end else if (pick < 80) begin
                push_request(CMD_DUMP, $urandom, t_port_id'($urandom_range(0, 65535)));
                if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
                    t = shadow_due[$urandom_range(0, shadow_count - 1)];
                end else begin
                    t = $urandom;
                end
                push_request(CMD_DUMP_AT, t, '0);
            end else if (pick < 90) begin
                if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
                    t = shadow_due[$urandom_range(0, shadow_count - 1)];
                end else begin
                    t = $urandom;
                end
                push_request(CMD_REMOVE, t, '0);
            end else if (pick < 97) begin
                // Noise over every code and the full field ranges; advances stay
                // small so that the clock does not hit its ceiling early.
                c = CMD_W'($urandom_range(0, 7));
                t = (c == CMD_ADVANCE) ? $urandom_range(0, 255) : $urandom;
                push_request(c, t, t_port_id'($urandom_range(0, 65535)));
            end else begin
                fill_and_empty();
            end
        end

        drain_results();
        play_rows(HEAD_ROWS, SCRIPT_ROWS);

        // Wait for everything owed, then a little longer in case the block
        // produces anything it should not.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== timed_event_queue.f =====
rtl/teq_pkg.sv
rtl/teq_req_if.sv
rtl/teq_res_if.sv
rtl/teq_cell.sv
rtl/teq_chain.sv
rtl/timed_event_queue.sv
bench/testbench.sv
